// File: rtl/core/hte_pkg.sv
// Package for the HTML text extractor: payload structs, sequencer codes,
// entity tables and the whitespace test. No dependencies.
package hte_pkg;

  // Sizes of the entity table and the decoder buffer
  localparam int ENT_NUM    = 7;
  localparam int ENT_MAXLEN = 6;
  localparam int ENT_BUF    = 5;

  // Per-request result cap
  localparam logic [3:0] RES_MAX = 4'd8;

  // Character codes
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Entity spellings, zero padded
  localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAXLEN] = '{
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},  // &amp;
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},  // &quot;
    '{8'h26, 8'h23, 8'h78, 8'h32, 8'h37, 8'h3B},  // &#x27;
    '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00},  // &#39;
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},  // &lt;
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},  // &gt;
    '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}   // &nbsp;
  };
  localparam logic [3:0] ENT_LEN [ENT_NUM] = '{4'd5, 4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd6};
  localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{
    8'h26, 8'h22, 8'h27, 8'h27, 8'h3C, 8'h3E, 8'h20
  };

  // Channel payloads
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } hte_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       text_done;
    logic       run_last;
  } hte_out_t;

  // One result before run_last is known
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       text_done;
  } hte_res_t;

  // Sequencer to result buffer
  typedef struct packed {
    logic     push;
    logic     close;
    hte_res_t res;
  } hte_rbuf_req_t;

  // Result buffer to sequencer
  typedef struct packed {
    logic push_ok;
    logic close_ok;
  } hte_rbuf_rsp_t;

  // Entity compare unit result
  typedef struct packed {
    logic       full;
    logic       prefix;
    logic [7:0] ch;
  } hte_match_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STRIP,
    S_DEC,
    S_FLUSH,
    S_END,
    S_FINISH
  } hte_state_t;

  typedef enum logic [1:0] {
    DK_START,
    DK_FULL,
    DK_GROW,
    DK_MISS
  } hte_dec_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c inside {CH_SP, [8'h09:8'h0D]});
  endfunction

endpackage

// File: rtl/core/hte_ent_match.sv
// Entity compare unit: checks the buffered entity bytes plus one new byte
// against every entity spelling. Depends on hte_pkg.
module hte_ent_match (
  input  logic [hte_pkg::ENT_BUF-1:0][7:0] ent_buf,
  input  logic [2:0]                       ent_cnt,
  input  logic [7:0]                       x_byte,
  output hte_pkg::hte_match_t              match
);
  import hte_pkg::*;

  logic [ENT_NUM-1:0] hit;
  logic [ENT_NUM-1:0] full;
  logic [3:0]         cnt_p1;

  assign cnt_p1 = {1'b0, ent_cnt} + 4'd1;

  // Compare the candidate against each spelling in parallel
  always_comb begin
    match = '0;
    for (int i = 0; i < ENT_NUM; i++) begin
      hit[i] = (ENT_LEN[i] >= cnt_p1);
      for (int j = 0; j < ENT_BUF; j++) begin
        if (3'(j) < ent_cnt) begin
          hit[i] = hit[i] && (ent_buf[j] == ENT_TEXT[i][j]);
        end
      end
      for (int j = 0; j < ENT_MAXLEN; j++) begin
        if (3'(j) == ent_cnt) begin
          hit[i] = hit[i] && (x_byte == ENT_TEXT[i][j]);
        end
      end
      full[i] = hit[i] && (ENT_LEN[i] == cnt_p1);
    end
    match.full   = |full;
    match.prefix = |(hit & ~full);
    for (int i = 0; i < ENT_NUM; i++) begin
      if (full[i]) begin
        match.ch = match.ch | ENT_CHAR[i];
      end
    end
  end

endmodule

// File: rtl/core/hte_res_buf.sv
// Result buffer: holds the newest result until the next one or the end of
// the request shows whether it is the last, then drives the output register.
// Depends on hte_pkg.
module hte_res_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hte_pkg::hte_rbuf_req_t req,
  output hte_pkg::hte_rbuf_rsp_t rsp,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hte_pkg::hte_out_t      out_data
);
  import hte_pkg::*;

  hte_res_t hold_r, hold_nxt;
  logic     hold_v_r, hold_v_nxt;
  hte_out_t out_r, out_nxt;
  logic     out_v_r, out_v_nxt;
  logic     out_free;

  assign out_free  = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Spill the held result on a new push or on close
  always_comb begin
    rsp.push_ok  = !hold_v_r || out_free;
    rsp.close_ok = !hold_v_r || out_free;
    hold_nxt     = hold_r;
    hold_v_nxt   = hold_v_r;
    out_nxt      = out_r;
    out_v_nxt    = out_v_r && !out_ready;
    if (req.push && rsp.push_ok) begin
      if (hold_v_r) begin
        out_nxt.out_byte   = hold_r.out_byte;
        out_nxt.byte_valid = hold_r.byte_valid;
        out_nxt.text_done  = hold_r.text_done;
        out_nxt.run_last   = 1'b0;
        out_v_nxt          = 1'b1;
      end
      hold_nxt   = req.res;
      hold_v_nxt = 1'b1;
    end else if (req.close && rsp.close_ok && hold_v_r) begin
      out_nxt.out_byte   = hold_r.out_byte;
      out_nxt.byte_valid = hold_r.byte_valid;
      out_nxt.text_done  = hold_r.text_done;
      out_nxt.run_last   = 1'b1;
      out_v_nxt          = 1'b1;
      hold_v_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTHESIS
  a_push_close_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.push && req.close))
    else $error("push and close in the same cycle");

  a_close_empties: assert property (@(posedge clk) disable iff (!rst_n)
    req.close && rsp.close_ok |=> !hold_v_r)
    else $error("held result survived close");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    req.push && rsp.push_ok |=> hold_v_r)
    else $error("pushed result not held");

  a_spill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r && req.push && rsp.push_ok |=> out_v_r && !out_r.run_last)
    else $error("spilled result missing or marked last");
`endif

endmodule

// File: rtl/core/html_text_extractor.sv
// HTML text extractor top level: request register, tag strip, entity
// decode sequencer and space normalizer. Depends on hte_pkg, hte_ent_match
// and hte_res_buf.
//
// One request at a time: in_ready is high only while the sequencer is idle.
// Besides each accepted text byte outside a tag, the decoder takes extra
// bytes (the inserted gap space or a byte replayed after an unmatched '&'),
// and a pending space may be written ahead of a byte. The sequencer feeds
// one byte per cycle through the shared entity compare unit, unless the
// result buffer cannot take a result or a pending space goes out first, and
// writes at most one result per cycle into the result buffer. An end request
// flushes each buffered entity byte, with a pending space ahead of them if
// one is due. A stalled output channel stalls the sequencer once the
// holding register and the output register are both full.
module html_text_extractor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hte_pkg::hte_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hte_pkg::hte_out_t out_data
);
  import hte_pkg::*;

  hte_state_t state_r, state_nxt;
  hte_in_t    in_r, in_nxt;

  // Tag strip state
  logic inside_tag_r, inside_tag_nxt;
  logic tag_gap_r, tag_gap_nxt;
  logic strip_wrote_r, strip_wrote_nxt;
  logic strip_last_sp_r, strip_last_sp_nxt;

  // Entity decode state and replay queue
  logic [ENT_BUF-1:0][7:0] ent_buf_r, ent_buf_nxt;
  logic [2:0]              ent_cnt_r, ent_cnt_nxt;
  logic [ENT_BUF-1:0][7:0] rq_r, rq_nxt;
  logic [2:0]              rq_cnt_r, rq_cnt_nxt;
  logic                    feed_gap_r, feed_gap_nxt;
  logic                    feed_c_r, feed_c_nxt;
  logic [2:0]              flush_idx_r, flush_idx_nxt;

  // Normalizer state
  logic space_pending_r, space_pending_nxt;
  logic norm_wrote_r, norm_wrote_nxt;

  logic [3:0] res_cnt_r, res_cnt_nxt;

  hte_rbuf_req_t rb_req;
  hte_rbuf_rsp_t rb_rsp;
  hte_match_t    match;

  logic [7:0] dec_x;
  logic [7:0] dec_y;
  logic       dec_yv;
  hte_dec_t   dec_kind;
  logic [2:0] flush_n;
  logic [7:0] flush_byte;
  logic       cap_full;
  logic       can_emit;

  logic [7:0] ny;
  logic       nv;
  logic       norm_want;
  logic [7:0] norm_byte;
  logic       norm_ok;
  logic       sp_set;
  logic       sp_clr;
  logic       wrote_set;

  logic     emit_go;
  hte_res_t emit_res;

  assign cap_full   = (res_cnt_r == RES_MAX);
  assign can_emit   = rb_rsp.push_ok || cap_full;
  assign flush_n    = (ent_cnt_r <= 3'(ENT_BUF)) ? ent_cnt_r : 3'd0;
  assign flush_byte = ent_buf_r[flush_idx_r];

  hte_ent_match u_match (
    .ent_buf (ent_buf_r),
    .ent_cnt (ent_cnt_r),
    .x_byte  (dec_x),
    .match   (match)
  );

  hte_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (rb_req),
    .rsp       (rb_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Pick the next decoder byte and classify the decode step
  always_comb begin
    if (rq_cnt_r != 3'd0) begin
      dec_x = rq_r[0];
    end else if (feed_gap_r) begin
      dec_x = CH_SP;
    end else begin
      dec_x = in_r.text_byte;
    end
    dec_y  = dec_x;
    dec_yv = 1'b0;
    if (ent_cnt_r == 3'd0 || ent_cnt_r > 3'(ENT_BUF)) begin
      dec_kind = DK_START;
      dec_yv   = (dec_x != CH_AMP);
    end else if (match.full) begin
      dec_kind = DK_FULL;
      dec_yv   = 1'b1;
      dec_y    = match.ch;
    end else if (match.prefix && ent_cnt_r < 3'(ENT_BUF)) begin
      dec_kind = DK_GROW;
    end else begin
      dec_kind = DK_MISS;
      dec_yv   = 1'b1;
      dec_y    = CH_AMP;
    end
  end

  // Normalize one byte: drop whitespace into a pending space, emit it lazily
  always_comb begin
    ny        = (state_r == S_FLUSH) ? flush_byte : dec_y;
    nv        = (state_r == S_FLUSH) ? 1'b1 : dec_yv;
    norm_want = 1'b0;
    norm_byte = ny;
    norm_ok   = 1'b1;
    sp_set    = 1'b0;
    sp_clr    = 1'b0;
    wrote_set = 1'b0;
    if (nv) begin
      if (is_ws(ny)) begin
        sp_set = 1'b1;
      end else if (space_pending_r && norm_wrote_r) begin
        norm_want = 1'b1;
        norm_byte = CH_SP;
        norm_ok   = 1'b0;
        sp_clr    = can_emit;
      end else begin
        norm_want = 1'b1;
        norm_ok   = can_emit;
        sp_clr    = can_emit;
        wrote_set = can_emit;
      end
    end
  end

  // Sequencer: next state and register updates
  always_comb begin
    state_nxt         = state_r;
    in_nxt            = in_r;
    inside_tag_nxt    = inside_tag_r;
    tag_gap_nxt       = tag_gap_r;
    strip_wrote_nxt   = strip_wrote_r;
    strip_last_sp_nxt = strip_last_sp_r;
    ent_buf_nxt       = ent_buf_r;
    ent_cnt_nxt       = ent_cnt_r;
    rq_nxt            = rq_r;
    rq_cnt_nxt        = rq_cnt_r;
    feed_gap_nxt      = feed_gap_r;
    feed_c_nxt        = feed_c_r;
    flush_idx_nxt     = flush_idx_r;
    space_pending_nxt = space_pending_r;
    norm_wrote_nxt    = norm_wrote_r;
    res_cnt_nxt       = res_cnt_r;
    in_ready          = 1'b0;
    emit_go           = 1'b0;
    emit_res          = '0;
    rb_req            = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          in_nxt        = in_data;
          res_cnt_nxt   = 4'd0;
          flush_idx_nxt = 3'd0;
          state_nxt     = in_data.end_of_text ? S_FLUSH : S_STRIP;
        end
      end

      // Strip tags and arm the gap space
      S_STRIP: begin
        if (in_r.text_byte == CH_LT) begin
          if (strip_wrote_r) begin
            tag_gap_nxt = 1'b1;
          end
          inside_tag_nxt = 1'b1;
        end else if (inside_tag_r) begin
          if (in_r.text_byte == CH_GT) begin
            inside_tag_nxt = 1'b0;
          end
        end else begin
          feed_gap_nxt = tag_gap_r && strip_wrote_r && !strip_last_sp_r &&
                         !is_ws(in_r.text_byte);
          feed_c_nxt        = 1'b1;
          tag_gap_nxt       = 1'b0;
          strip_wrote_nxt   = 1'b1;
          strip_last_sp_nxt = is_ws(in_r.text_byte);
        end
        state_nxt = S_DEC;
      end

      // Advance one decoder byte per cycle while the normalizer accepts it
      S_DEC: begin
        if (rq_cnt_r == 3'd0 && !feed_gap_r && !feed_c_r) begin
          state_nxt = S_FINISH;
        end else begin
          emit_go  = norm_want && can_emit;
          emit_res = '{out_byte: norm_byte, byte_valid: 1'b1, text_done: 1'b0};
          if (sp_set) space_pending_nxt = 1'b1;
          if (sp_clr) space_pending_nxt = 1'b0;
          if (wrote_set) norm_wrote_nxt = 1'b1;
          if (norm_ok) begin
            // Consume the byte from its source
            if (rq_cnt_r != 3'd0) begin
              for (int k = 0; k < ENT_BUF - 1; k++) begin
                rq_nxt[k] = rq_r[k+1];
              end
              rq_cnt_nxt = rq_cnt_r - 3'd1;
            end else if (feed_gap_r) begin
              feed_gap_nxt = 1'b0;
            end else begin
              feed_c_nxt = 1'b0;
            end
            case (dec_kind)
              DK_START: begin
                if (dec_x == CH_AMP) begin
                  ent_buf_nxt[0] = dec_x;
                  ent_cnt_nxt    = 3'd1;
                end else begin
                  ent_cnt_nxt = 3'd0;
                end
              end
              DK_FULL: begin
                ent_cnt_nxt = 3'd0;
              end
              DK_GROW: begin
                for (int k = 0; k < ENT_BUF; k++) begin
                  if (3'(k) == ent_cnt_r) begin
                    ent_buf_nxt[k] = dec_x;
                  end
                end
                ent_cnt_nxt = ent_cnt_r + 3'd1;
              end
              DK_MISS: begin
                // Replay the bytes after the literal '&', then this byte
                for (int k = 0; k < ENT_BUF - 1; k++) begin
                  rq_nxt[k] = (3'(k + 1) < ent_cnt_r) ? ent_buf_r[k+1] : dec_x;
                end
                rq_nxt[ENT_BUF-1] = dec_x;
                rq_cnt_nxt        = ent_cnt_r;
                ent_cnt_nxt       = 3'd0;
              end
              default: begin
                ent_cnt_nxt = 3'd0;
              end
            endcase
          end
        end
      end

      // Emit buffered entity bytes literally
      S_FLUSH: begin
        if (flush_idx_r == flush_n) begin
          state_nxt = S_END;
        end else begin
          emit_go  = norm_want && can_emit;
          emit_res = '{out_byte: norm_byte, byte_valid: 1'b1, text_done: 1'b0};
          if (sp_set) space_pending_nxt = 1'b1;
          if (sp_clr) space_pending_nxt = 1'b0;
          if (wrote_set) norm_wrote_nxt = 1'b1;
          if (norm_ok) begin
            flush_idx_nxt = flush_idx_r + 3'd1;
          end
        end
      end

      // Give the end result and clear every stage
      S_END: begin
        if (can_emit) begin
          emit_go           = 1'b1;
          emit_res          = '{out_byte: 8'h00, byte_valid: 1'b0, text_done: 1'b1};
          inside_tag_nxt    = 1'b0;
          tag_gap_nxt       = 1'b0;
          strip_wrote_nxt   = 1'b0;
          strip_last_sp_nxt = 1'b0;
          ent_cnt_nxt       = 3'd0;
          space_pending_nxt = 1'b0;
          norm_wrote_nxt    = 1'b0;
          state_nxt         = S_FINISH;
        end
      end

      // Release the held result as the last of this request
      S_FINISH: begin
        rb_req.close = 1'b1;
        if (rb_rsp.close_ok) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Push the result unless the per-request cap is reached
    if (emit_go && !cap_full) begin
      rb_req.push = 1'b1;
      rb_req.res  = emit_res;
      res_cnt_nxt = res_cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      inside_tag_r    <= 1'b0;
      tag_gap_r       <= 1'b0;
      strip_wrote_r   <= 1'b0;
      strip_last_sp_r <= 1'b0;
      ent_cnt_r       <= 3'd0;
      rq_cnt_r        <= 3'd0;
      feed_gap_r      <= 1'b0;
      feed_c_r        <= 1'b0;
      flush_idx_r     <= 3'd0;
      space_pending_r <= 1'b0;
      norm_wrote_r    <= 1'b0;
      res_cnt_r       <= 4'd0;
    end else begin
      state_r         <= state_nxt;
      inside_tag_r    <= inside_tag_nxt;
      tag_gap_r       <= tag_gap_nxt;
      strip_wrote_r   <= strip_wrote_nxt;
      strip_last_sp_r <= strip_last_sp_nxt;
      ent_cnt_r       <= ent_cnt_nxt;
      rq_cnt_r        <= rq_cnt_nxt;
      feed_gap_r      <= feed_gap_nxt;
      feed_c_r        <= feed_c_nxt;
      flush_idx_r     <= flush_idx_nxt;
      space_pending_r <= space_pending_nxt;
      norm_wrote_r    <= norm_wrote_nxt;
      res_cnt_r       <= res_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    ent_buf_r <= ent_buf_nxt;
    rq_r      <= rq_nxt;
  end

endmodule
